### sv/heightfield_height_query_top_defines.svh
// Assertion macros used by the checker file hhq_chk.sv.
`ifndef HEIGHTFIELD_HEIGHT_QUERY_TOP_DEFINES_SVH
`define HEIGHTFIELD_HEIGHT_QUERY_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define HHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst is high.
`define HHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/hhq_pkg.sv
package hhq_pkg;

  localparam int GRID_POINTS_DEF  = 32;
  localparam int CENTER_INDEX_DEF = 16;
  localparam int CELL_SIZE_DEF    = 5;
  localparam int FRAC_BITS_DEF    = 8;

  localparam int OP_W     = 1;
  localparam int GRID_W   = 5;
  localparam int HEIGHT_W = 16;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 1;

  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_RD,
    ST_MUL,
    ST_SUM,
    ST_QDIV,
    ST_FIN
  } hhq_state_t;

endpackage

### sv/hhq_if.sv
interface hhq_cmd_if import hhq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic [GRID_W-1:0]          grid_x;
  logic [GRID_W-1:0]          grid_z;
  logic signed [HEIGHT_W-1:0] height_value;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_z;

  modport source (output valid, op, grid_x, grid_z, height_value, pos_x, pos_z,
                  input ready);
  modport sink (input valid, op, grid_x, grid_z, height_value, pos_x, pos_z,
                output ready);
endinterface

interface hhq_res_if import hhq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [HEIGHT_W-1:0] height_out;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, height_out, status, input ready);
  modport sink (input valid, height_out, status, output ready);
endinterface

### sv/hhq_ram.sv
module hhq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/hhq_cdiv.sv
// Floor division of an unsigned word by a constant, three registered stages:
// reciprocal estimate, back-multiply, one correction step.
module hhq_cdiv #(
  parameter int     W  = 18,
  parameter int     QW = 8,
  parameter int     RW = 11,
  parameter longint D  = 1280
) (
  input  logic          clk,
  input  logic [W-1:0]  a,
  output logic [QW-1:0] q,
  output logic [RW-1:0] r
);

  localparam longint     M   = (longint'(1) << W) / D;
  localparam int         MW  = $clog2(M + 1);
  localparam int         EW  = W + MW;
  localparam int         BW  = QW + RW;
  localparam logic [W-1:0] DV = W'(D);

  logic [EW-1:0] est;
  logic [W-1:0]  a1, a2, prod, rem;
  logic [QW-1:0] q0, q1;

  // estimate is exact or one low
  assign est = EW'(a) * EW'(M);
  assign rem = a2 - prod;

  always_ff @(posedge clk) begin
    a1   <= a;
    q0   <= QW'(est >> W);
    a2   <= a1;
    q1   <= q0;
    prod <= W'(BW'(q0) * BW'(D));
    if (rem >= DV) begin
      q <= q1 + QW'(1);
      r <= RW'(rem - DV);
    end else begin
      q <= q1;
      r <= RW'(rem);
    end
  end

endmodule

### sv/heightfield_height_query_top.sv
// Heightfield height query.
// cmd channel (valid/ready) carries one word per item: op selects a vertex
// height write (grid_x, grid_z, height_value) or a height query (pos_x,
// pos_z). res channel returns one word per query: height_out and status;
// writes return nothing. A query outside the grid returns status 1, height 0.
// A write is stored as it is accepted. A query is not overlapped: cmd.ready
// stays low until its result is loaded (sooner when outside the grid). The
// query time is set by the single read port of the height RAM (four reads
// per query) and the 3-stage constant dividers (x/z pair, then plane).
// The result sits in an output register; cmd keeps accepting while it waits.
// When res stalls and a second query finishes, that query holds in its last
// step and cmd.ready stays low until the output register frees up.
// Reset: synchronous rst starts a clearing pass that writes zero to every
// entry of the height RAM (GRID_POINTS*GRID_POINTS entries), cmd.ready low.
module heightfield_height_query_top import hhq_pkg::*; #(
  parameter int GRID_POINTS  = GRID_POINTS_DEF,
  parameter int CENTER_INDEX = CENTER_INDEX_DEF,
  parameter int CELL_SIZE    = CELL_SIZE_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  hhq_cmd_if.sink      cmd,
  hhq_res_if.source    res
);

  localparam int     DEPTH = GRID_POINTS * GRID_POINTS;
  localparam int     AW    = $clog2(DEPTH);
  localparam int     XW    = $clog2(GRID_POINTS);
  localparam int     AFW   = 17;
  localparam int     GCW   = 9;

  localparam longint S     = longint'(CELL_SIZE) << FRAC_BITS;
  localparam int     SW    = $clog2(S + 1);
  localparam int     SDW   = SW + 1;

  // position divider: offset keeps the dividend non-negative
  localparam longint KP    = (32768 + S - 1) / S;
  localparam longint OFFP  = KP * S;
  localparam longint AMAXP = 32768 + OFFP;
  localparam int     PW    = $clog2(AMAXP + 1);
  localparam longint QMAXP = ((longint'(1) << PW) - 1) / S;
  localparam int     QWP   = $clog2(QMAXP + 1);
  localparam int     IW    = ((QWP > GCW) ? QWP : GCW) + 2;

  // plane divider
  localparam longint HSPAN = 65535;
  localparam longint K2    = 2 * HSPAN + 1;
  localparam longint OFF2H = K2 * S + S / 2;
  localparam longint A2MAX = 2 * HSPAN * S + OFF2H;
  localparam int     A2W   = $clog2(A2MAX + 1);
  localparam longint QMAX2 = ((longint'(1) << A2W) - 1) / S;
  localparam int     QW2   = $clog2(QMAX2 + 1);
  localparam int     RSW   = QW2 + 2;

  localparam int     HDW   = HEIGHT_W + 1;
  localparam int     PRW   = SDW + HDW;

  localparam logic [1:0]    DIV_WAIT = 2'd2;
  localparam logic [1:0]    RD_LAST  = 2'd3;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  localparam logic signed [RSW-1:0] SAT_HI = RSW'(32767);
  localparam logic signed [RSW-1:0] SAT_LO = -RSW'(32768);

  hhq_state_t state, state_next;
  logic [1:0] cnt, cnt_next;
  logic [AW-1:0] clr_cnt;

  logic cmd_ready_c;
  logic res_load;

  logic [PW-1:0]  ax_r, az_r;
  logic [QWP-1:0] qx, qz;
  logic [SW-1:0]  rx, rz;

  logic [XW-1:0]  cx_r, cz_r;
  logic signed [SDW-1:0] dx_r, dz_r;
  logic outside_r;

  logic signed [HEIGHT_W-1:0] h0_r, h1_r, h2_r, h3;
  logic signed [PRW-1:0] p1_r, p2_r;
  logic [A2W-1:0] a2_r;
  logic [QW2-1:0] q2;
  logic [SW-1:0]  r2;

  logic                       out_valid;
  logic signed [HEIGHT_W-1:0] out_height;
  logic [STATUS_W-1:0]        out_status;

  // RAM ports
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;

  logic [AFW-1:0] wr_full, rd_full;
  logic           wr_in_grid;

  logic signed [PW:0]    ax_ext, az_ext;
  logic signed [IW-1:0]  cx_full, cz_full;
  logic                  outside_c;
  logic signed [SDW-1:0] dx_c, dz_c;

  logic signed [SDW-1:0] ma, mb;
  logic signed [HDW-1:0] da, db;
  logic signed [A2W:0]   a2_ext;
  logic signed [RSW-1:0] fin_sum;
  logic signed [HEIGHT_W-1:0] fin_height;

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      cnt     <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    cmd_ready_c = 1'b0;
    res_load    = 1'b0;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_ready_c = 1'b1;
        if (cmd.valid && cmd.op == OP_QUERY) begin
          state_next = ST_DIV;
          cnt_next   = '0;
        end
      end
      ST_DIV: begin
        if (cnt == DIV_WAIT) begin
          state_next = ST_CHK;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      ST_CHK: begin
        state_next = outside_c ? ST_FIN : ST_RD;
        cnt_next   = '0;
      end
      ST_RD: begin
        cnt_next = cnt + 2'd1;
        if (cnt == RD_LAST) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_QDIV;
        cnt_next   = '0;
      end
      ST_QDIV: begin
        if (cnt == DIV_WAIT) begin
          state_next = ST_FIN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid || res.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cmd.ready = cmd_ready_c;

  // ---------------------------------------------------------------- height RAM
  assign wr_in_grid = (GCW'(cmd.grid_x) < GCW'(GRID_POINTS)) &&
                      (GCW'(cmd.grid_z) < GCW'(GRID_POINTS));
  assign wr_full = AFW'(cmd.grid_z) * AFW'(GRID_POINTS) + AFW'(cmd.grid_x);
  assign rd_full = (AFW'(cz_r) + AFW'(cnt[1])) * AFW'(GRID_POINTS) +
                   AFW'(cx_r) + AFW'(cnt[0]);

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = cmd.valid && cmd_ready_c && cmd.op == OP_WRITE && wr_in_grid;
      ram_waddr = wr_full[AW-1:0];
      ram_wdata = cmd.height_value;
    end
  end

  assign ram_re    = (state == ST_RD);
  assign ram_raddr = rd_full[AW-1:0];

  hhq_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign h3 = $signed(ram_rdata);

  // ---------------------------------------------------------------- cell search
  assign ax_ext = (PW + 1)'(cmd.pos_x) + (PW + 1)'(OFFP);
  assign az_ext = (PW + 1)'(OFFP) - (PW + 1)'(cmd.pos_z);

  hhq_cdiv #(.W(PW), .QW(QWP), .RW(SW), .D(S)) u_div_x (
    .clk (clk), .a (ax_r), .q (qx), .r (rx)
  );

  hhq_cdiv #(.W(PW), .QW(QWP), .RW(SW), .D(S)) u_div_z (
    .clk (clk), .a (az_r), .q (qz), .r (rz)
  );

  assign cx_full = $signed(IW'(qx)) - IW'(KP) + IW'(CENTER_INDEX);
  assign cz_full = $signed(IW'(qz)) - IW'(KP) + IW'(CENTER_INDEX);
  assign outside_c = (cx_full < 0) || (cx_full > IW'(GRID_POINTS - 2)) ||
                     (cz_full < 0) || (cz_full > IW'(GRID_POINTS - 2));

  // offsets from the cell's upper-right corner
  assign dx_c = $signed({1'b0, rx}) - SDW'(S);
  assign dz_c = SDW'(0) - $signed({1'b0, rz});

  // ---------------------------------------------------------------- plane
  always_comb begin
    if (dz_r > dx_r) begin
      ma = dz_r;
      da = HDW'(h0_r) - HDW'(h2_r);
      mb = dx_r;
      db = HDW'(h0_r) - HDW'(h1_r);
    end else begin
      ma = dx_r;
      da = HDW'(h3) - HDW'(h2_r);
      mb = dz_r;
      db = HDW'(h3) - HDW'(h1_r);
    end
  end

  assign a2_ext = (A2W + 1)'(p1_r) - (A2W + 1)'(p2_r) + (A2W + 1)'(OFF2H);

  hhq_cdiv #(.W(A2W), .QW(QW2), .RW(SW), .D(S)) u_div_plane (
    .clk (clk), .a (a2_r), .q (q2), .r (r2)
  );

  // the rounding remainder is not needed
  assign fin_sum = $signed(RSW'(q2)) - RSW'(K2) + RSW'(h1_r) +
                   RSW'(r2 & '0);

  always_comb begin
    if (fin_sum > SAT_HI) begin
      fin_height = 16'sh7FFF;
    end else if (fin_sum < SAT_LO) begin
      fin_height = -16'sh8000;
    end else begin
      fin_height = HEIGHT_W'(fin_sum);
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd_ready_c && cmd.op == OP_QUERY) begin
      ax_r <= ax_ext[PW-1:0];
      az_r <= az_ext[PW-1:0];
    end
    if (state == ST_CHK) begin
      cx_r      <= cx_full[XW-1:0];
      cz_r      <= cz_full[XW-1:0];
      dx_r      <= dx_c;
      dz_r      <= dz_c;
      outside_r <= outside_c;
    end
    if (state == ST_RD) begin
      case (cnt)
        2'd1:    h0_r <= h3;
        2'd2:    h1_r <= h3;
        2'd3:    h2_r <= h3;
        default: h0_r <= h0_r;
      endcase
    end
    if (state == ST_MUL) begin
      p1_r <= PRW'(ma) * PRW'(da);
      p2_r <= PRW'(mb) * PRW'(db);
    end
    if (state == ST_SUM) begin
      a2_r <= a2_ext[A2W-1:0];
    end
  end

  // ---------------------------------------------------------------- result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_height <= outside_r ? '0 : fin_height;
      out_status <= outside_r ? STATUS_OUTSIDE : STATUS_OK;
    end
  end

  assign res.valid      = out_valid;
  assign res.height_out = out_height;
  assign res.status     = out_status;

endmodule

### sv/hhq_chk.sv
`include "heightfield_height_query_top_defines.svh"

module hhq_chk import hhq_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic [OP_W-1:0]            cmd_op,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic signed [HEIGHT_W-1:0] res_height,
  input logic [STATUS_W-1:0]        res_status
);

  // a stalled result word holds
  `HHQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_height) && $stable(res_status), "result word changed while stalled")

  // outside the grid always reads as zero height
  `HHQ_ASSERT_NOW(a_outside_zero, res_valid && res_status == STATUS_OUTSIDE, res_height == '0, "outside result with nonzero height")

  // a query occupies the block: no word taken in the next cycle
  `HHQ_ASSERT_NEXT(a_query_busy, cmd_valid && cmd_ready && cmd_op == OP_QUERY, !cmd_ready, "cmd taken right after a query")

  // a write never produces a result word
  `HHQ_ASSERT_NEXT(a_write_silent, cmd_valid && cmd_ready && cmd_op == OP_WRITE && !res_valid, !res_valid, "result word after a write")

endmodule

bind heightfield_height_query_top hhq_chk u_hhq_chk (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_op     (cmd.op),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_height (res.height_out),
  .res_status (res.status)
);
